// ===== src/bracket_pair_matcher_defines.svh =====
// ----------------------------------------------------------------------------
// Bracket pair matcher assertion macros
// Shared concurrent assertion forms used by the RTL of the bracket matcher.
// ----------------------------------------------------------------------------
`ifndef BRACKET_PAIR_MATCHER_DEFINES_SVH
`define BRACKET_PAIR_MATCHER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define BPM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define BPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/bpm_pkg.sv =====
// ----------------------------------------------------------------------------
// Bracket pair matcher package
// Default sizes, character codes, bracket types, stack operations and the
// byte classifier shared by the matcher modules.
// ----------------------------------------------------------------------------
package bpm_pkg;

  // Default sizes.
  localparam int DEF_STACK_DEPTH = 64;
  localparam int DEF_POS_WIDTH   = 16;
  localparam int OUT_POS_WIDTH   = 16;

  // Recognized characters.
  localparam logic [7:0] CH_RND_OPEN  = 8'h28;
  localparam logic [7:0] CH_RND_CLOSE = 8'h29;
  localparam logic [7:0] CH_SQR_OPEN  = 8'h5B;
  localparam logic [7:0] CH_SQR_CLOSE = 8'h5D;
  localparam logic [7:0] CH_CRL_OPEN  = 8'h7B;
  localparam logic [7:0] CH_CRL_CLOSE = 8'h7D;

  // Bracket types.
  typedef logic [1:0] btype_t;
  localparam btype_t BT_NONE   = 2'd0;
  localparam btype_t BT_ROUND  = 2'd1;
  localparam btype_t BT_SQUARE = 2'd2;
  localparam btype_t BT_CURLY  = 2'd3;

  // Per-entry set of bracket types present, one bit per type.
  typedef logic [2:0] tmask_t;

  // Operations applied to every cell of the stack at once.
  typedef logic [1:0] stk_op_t;
  localparam stk_op_t STK_HOLD  = 2'd0;
  localparam stk_op_t STK_PUSH  = 2'd1;
  localparam stk_op_t STK_POP   = 2'd2;
  localparam stk_op_t STK_CLEAR = 2'd3;

  typedef struct packed {
    logic   opens;
    btype_t btype;
  } bclass_t;

  // Sort a byte into bracket type and direction.
  function automatic bclass_t classify(input logic [7:0] c);
    bclass_t r;
    r.opens = 1'b0;
    r.btype = BT_NONE;
    case (c)
      CH_RND_OPEN:  begin r.opens = 1'b1; r.btype = BT_ROUND;  end
      CH_RND_CLOSE: begin r.btype = BT_ROUND;  end
      CH_SQR_OPEN:  begin r.opens = 1'b1; r.btype = BT_SQUARE; end
      CH_SQR_CLOSE: begin r.btype = BT_SQUARE; end
      CH_CRL_OPEN:  begin r.opens = 1'b1; r.btype = BT_CURLY;  end
      CH_CRL_CLOSE: begin r.btype = BT_CURLY;  end
      default:      begin r.btype = BT_NONE;   end
    endcase
    return r;
  endfunction

  // Mask bit of a bracket type; no bit for a non-bracket.
  function automatic tmask_t type_bit(input btype_t t);
    tmask_t m;
    case (t)
      BT_ROUND:  m = 3'b001;
      BT_SQUARE: m = 3'b010;
      BT_CURLY:  m = 3'b100;
      default:   m = 3'b000;
    endcase
    return m;
  endfunction

endpackage

// ===== src/bpm_in_if.sv =====
// ----------------------------------------------------------------------------
// Bracket pair matcher input channel
// Valid/ready channel carrying one text byte and its end-of-text flag.
// ----------------------------------------------------------------------------
interface bpm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

// ===== src/bpm_out_if.sv =====
// ----------------------------------------------------------------------------
// Bracket pair matcher result channel
// Valid/ready channel carrying one result per text byte.
// ----------------------------------------------------------------------------
interface bpm_out_if;
  logic        valid;
  logic        ready;
  logic        pair_found;
  logic [15:0] open_pos;
  logic [15:0] close_pos;
  logic        overflow;

  modport source (output valid, output pair_found, output open_pos,
                  output close_pos, output overflow, input ready);
  modport sink   (input valid, input pair_found, input open_pos,
                  input close_pos, input overflow, output ready);
endinterface

// ===== src/bracket_pair_matcher.sv =====
// ----------------------------------------------------------------------------
// Bracket pair matcher
// Numbers text bytes, stacks opening brackets and reports each matched pair.
// ----------------------------------------------------------------------------
// A byte request needs no search when it is not a closing bracket, or when
// its matching opener sits on top of the stack. A closing bracket whose
// nearest matching opener lies deeper in the stack starts a search:
// the stack is a row of cells with only cell zero compared, and it pops one
// entry per cycle until the opener reaches the top. A closer with no matching
// opener anywhere in the stack is seen at once from the type set kept in the
// top cell. Results pass through a single output register.
// A new byte is taken only when that register is empty or its result is
// accepted in the same cycle, so a stalled receiver holds off the input, and
// no byte is taken while a search is running.
module bracket_pair_matcher
  import bpm_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int POS_WIDTH   = DEF_POS_WIDTH
) (
  input logic     clk,
  input logic     rst_n,
  bpm_in_if.sink  in_chan,
  bpm_out_if.source out_chan
);

`include "bracket_pair_matcher_defines.svh"

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_SEARCH = 1'b1;
  localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};

  logic                 state_r, state_nxt;
  logic [POS_WIDTH-1:0] pos_r, pos_nxt;
  logic                 overflow_r, overflow_nxt;
  btype_t               stype_r, stype_nxt;
  logic [POS_WIDTH-1:0] here_r, here_nxt;
  logic                 slast_r, slast_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic                     out_found_r, out_found_nxt;
  logic [OUT_POS_WIDTH-1:0] out_open_r, out_open_nxt;
  logic [OUT_POS_WIDTH-1:0] out_close_r, out_close_nxt;
  logic                     out_ovf_r, out_ovf_nxt;

  stk_op_t              op;
  tmask_t               top_mask;
  btype_t               top_type;
  logic [POS_WIDTH-1:0] top_pos;
  logic                 full;

  logic    accept;
  logic    load_out;
  logic    found;
  logic [POS_WIDTH-1:0] found_open;
  logic [POS_WIDTH-1:0] found_close;
  bclass_t cls;
  logic    hit;

  // Output positions carry the low bits of the position, zero-extended.
  logic [31:0] open_ext, close_ext;

  assign in_chan.ready = (state_r == ST_IDLE) && (!out_valid_r || out_chan.ready);
  assign accept        = in_chan.valid && in_chan.ready;
  assign cls           = classify(in_chan.ch);
  assign hit           = |(top_mask & type_bit(cls.btype));

  bpm_stack #(
    .STACK_DEPTH (STACK_DEPTH),
    .POS_WIDTH   (POS_WIDTH)
  ) u_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .push_type (cls.btype),
    .push_pos  (pos_r),
    .top_mask  (top_mask),
    .top_type  (top_type),
    .top_pos   (top_pos),
    .full      (full)
  );

  // Request handling, stack control and the search state machine.
  always_comb begin
    state_nxt    = state_r;
    pos_nxt      = pos_r;
    overflow_nxt = overflow_r;
    stype_nxt    = stype_r;
    here_nxt     = here_r;
    slast_nxt    = slast_r;
    op           = STK_HOLD;
    load_out     = 1'b0;
    found        = 1'b0;
    found_open   = top_pos;
    found_close  = pos_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          load_out = 1'b1;
          if (cls.btype != BT_NONE && cls.opens) begin
            if (full) begin
              overflow_nxt = 1'b1;
            end
            op = in_chan.last ? STK_CLEAR : (full ? STK_HOLD : STK_PUSH);
          end else if (cls.btype != BT_NONE && hit) begin
            if (top_type == cls.btype) begin
              found = 1'b1;
              op    = in_chan.last ? STK_CLEAR : STK_POP;
            end else begin
              // The opener lies deeper: drop the top and keep looking.
              op        = STK_POP;
              load_out  = 1'b0;
              state_nxt = ST_SEARCH;
              stype_nxt = cls.btype;
              here_nxt  = pos_r;
              slast_nxt = in_chan.last;
            end
          end else begin
            op = in_chan.last ? STK_CLEAR : STK_HOLD;
          end
          // Advance or saturate the position, or reset it after the last byte.
          if (in_chan.last) begin
            pos_nxt = '0;
          end else if (pos_r == POS_MAX) begin
            overflow_nxt = 1'b1;
          end else begin
            pos_nxt = pos_r + POS_WIDTH'(1);
          end
        end
      end
      ST_SEARCH: begin
        found_close = here_r;
        if (top_type == stype_r) begin
          found     = 1'b1;
          load_out  = 1'b1;
          op        = slast_r ? STK_CLEAR : STK_POP;
          state_nxt = ST_IDLE;
        end else begin
          op = STK_POP;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result register; the slot is always free when a result is loaded.
  assign open_ext  = 32'(found_open);
  assign close_ext = 32'(found_close);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_open_nxt  = out_open_r;
    out_close_nxt = out_close_r;
    out_ovf_nxt   = out_ovf_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_found_nxt = found;
      out_open_nxt  = found ? open_ext[OUT_POS_WIDTH-1:0] : '0;
      out_close_nxt = found ? close_ext[OUT_POS_WIDTH-1:0] : '0;
      out_ovf_nxt   = overflow_nxt;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      overflow_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      overflow_r  <= overflow_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    stype_r     <= stype_nxt;
    here_r      <= here_nxt;
    slast_r     <= slast_nxt;
    out_found_r <= out_found_nxt;
    out_open_r  <= out_open_nxt;
    out_close_r <= out_close_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.pair_found = out_found_r;
  assign out_chan.open_pos   = out_open_r;
  assign out_chan.close_pos  = out_close_r;
  assign out_chan.overflow   = out_ovf_r;

  // A search only runs while the wanted opener is still in the stack.
  `BPM_ASSERT_SAME(a_search_hit, clk, rst_n, state_r == ST_SEARCH,
    (top_mask & type_bit(stype_r)) != '0, "search lost its matching opener")

  // The result slot is empty whenever a search is in progress.
  `BPM_ASSERT_SAME(a_search_slot, clk, rst_n, state_r == ST_SEARCH,
    !out_valid_r, "result slot busy during search")

  // The overflow flag only clears on reset.
  `BPM_ASSERT_NEXT(a_ovf_sticky, clk, rst_n, overflow_r, overflow_r,
    "overflow flag cleared")

  // A search always ends by delivering a result.
  `BPM_ASSERT_NEXT(a_search_end, clk, rst_n,
    state_r == ST_SEARCH && top_type == stype_r, out_valid_r && out_found_r,
    "search ended without a pair")

endmodule

// ===== src/bpm_cell.sv =====
// ----------------------------------------------------------------------------
// Bracket stack cell
// Holds one stack entry. A push takes the entry of the neighbor above, a pop
// takes the entry of the neighbor below. The type mask records every bracket
// type held in this cell or deeper; a zero mask marks an empty cell.
// ----------------------------------------------------------------------------
module bpm_cell
  import bpm_pkg::*;
#(
  parameter int POS_WIDTH = DEF_POS_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  stk_op_t              op,
  input  tmask_t               up_mask,
  input  btype_t               up_type,
  input  logic [POS_WIDTH-1:0] up_pos,
  input  tmask_t               dn_mask,
  input  btype_t               dn_type,
  input  logic [POS_WIDTH-1:0] dn_pos,
  output tmask_t               mask,
  output btype_t               btype,
  output logic [POS_WIDTH-1:0] pos
);

  tmask_t               mask_r, mask_nxt;
  btype_t               type_r, type_nxt;
  logic [POS_WIDTH-1:0] pos_r, pos_nxt;

  // Select the entry this cell holds next.
  always_comb begin
    mask_nxt = mask_r;
    type_nxt = type_r;
    pos_nxt  = pos_r;
    case (op)
      STK_PUSH: begin
        mask_nxt = up_mask;
        type_nxt = up_type;
        pos_nxt  = up_pos;
      end
      STK_POP: begin
        mask_nxt = dn_mask;
        type_nxt = dn_type;
        pos_nxt  = dn_pos;
      end
      STK_CLEAR: begin
        mask_nxt = '0;
      end
      default: begin
        mask_nxt = mask_r;
      end
    endcase
  end

  // The mask doubles as the valid flag and is cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else begin
      mask_r <= mask_nxt;
    end
  end

  // Entry payload needs no reset.
  always_ff @(posedge clk) begin
    type_r <= type_nxt;
    pos_r  <= pos_nxt;
  end

  assign mask  = mask_r;
  assign btype = type_r;
  assign pos   = pos_r;

endmodule

// ===== src/bpm_stack.sv =====
// ----------------------------------------------------------------------------
// Bracket stack
// A row of cells with the top of stack in cell zero. All cells shift
// together on a push or pop, so only the top entry is examined for matches.
// ----------------------------------------------------------------------------
module bpm_stack
  import bpm_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int POS_WIDTH   = DEF_POS_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  stk_op_t              op,
  input  btype_t               push_type,
  input  logic [POS_WIDTH-1:0] push_pos,
  output tmask_t               top_mask,
  output btype_t               top_type,
  output logic [POS_WIDTH-1:0] top_pos,
  output logic                 full
);

  tmask_t               mask_w [STACK_DEPTH];
  btype_t               type_w [STACK_DEPTH];
  logic [POS_WIDTH-1:0] pos_w  [STACK_DEPTH];

  // New top entry carries the type set of the entries it covers.
  tmask_t push_mask;
  assign push_mask = mask_w[0] | type_bit(push_type);

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    tmask_t               up_mask, dn_mask;
    btype_t               up_type, dn_type;
    logic [POS_WIDTH-1:0] up_pos, dn_pos;

    // Neighbor above: the push data for the top cell.
    if (i == 0) begin : g_top
      assign up_mask = push_mask;
      assign up_type = push_type;
      assign up_pos  = push_pos;
    end else begin : g_mid
      assign up_mask = mask_w[i-1];
      assign up_type = type_w[i-1];
      assign up_pos  = pos_w[i-1];
    end

    // Neighbor below: an empty entry past the bottom cell.
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign dn_mask = '0;
      assign dn_type = BT_NONE;
      assign dn_pos  = '0;
    end else begin : g_upper
      assign dn_mask = mask_w[i+1];
      assign dn_type = type_w[i+1];
      assign dn_pos  = pos_w[i+1];
    end

    bpm_cell #(
      .POS_WIDTH (POS_WIDTH)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .op      (op),
      .up_mask (up_mask),
      .up_type (up_type),
      .up_pos  (up_pos),
      .dn_mask (dn_mask),
      .dn_type (dn_type),
      .dn_pos  (dn_pos),
      .mask    (mask_w[i]),
      .btype   (type_w[i]),
      .pos     (pos_w[i])
    );
  end

  assign top_mask = mask_w[0];
  assign top_type = type_w[0];
  assign top_pos  = pos_w[0];
  assign full     = |mask_w[STACK_DEPTH-1];

endmodule
